/* hw/rtl/sai_pkg.sv */
// ----------------------------------------------------------------------------
// sai_pkg
// Shared constants, types and command codes for the sorted array insert
// counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sai_pkg;

    localparam int SIZE          = 64;
    localparam int VALUE_BITS    = 16;
    localparam int VALUE_FIELD_W = 16;
    localparam int CNT_FIELD_W   = 7;
    localparam int CNT_W         = $clog2(SIZE + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic [VALUE_BITS-1:0]    t_entry;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [VALUE_FIELD_W-1:0] t_value_field;
    typedef logic [CNT_FIELD_W-1:0]   t_cnt_field;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic   clear;
        logic   ins;
        t_entry value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* hw/rtl/sai_if.sv */
// ----------------------------------------------------------------------------
// sai_if
// Request and response channels of the sorted array insert counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface sai_in_if import sai_pkg::*; ();
    logic         valid;
    logic         ready;
    logic         cmd;
    t_value_field value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
    modport mon    (input valid, ready, cmd, value);
endinterface

interface sai_out_if import sai_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cnt_field comparisons;
    t_cnt_field movements;
    logic       stored;
    logic       lost_last;

    modport source (output valid, comparisons, movements, stored, lost_last, input ready);
    modport sink   (input valid, comparisons, movements, stored, lost_last, output ready);
    modport mon    (input valid, ready, comparisons, movements, stored, lost_last);
endinterface

`default_nettype wire

/* hw/rtl/sai_cell.sv */
// ----------------------------------------------------------------------------
// sai_cell
// One slot of the sorted chain: holds an entry, compares it with the
// incoming value and takes the value or its left neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_cell import sai_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_entry     i_prev_entry,
    input  wire logic       i_prev_le,
    output t_entry          o_entry,
    output logic            o_le
);

    t_entry r_entry;
    t_entry n_entry;

    // occupied and not larger than the value: stays where it is
    assign o_le    = (r_entry != '0) && (r_entry <= i_ctrl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.clear) begin
            n_entry = '0;
        end else if (i_ctrl.ins && !o_le) begin
            // first slot past the kept prefix takes the value, the rest shift up
            n_entry = i_prev_le ? i_ctrl.value : i_prev_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sai_therm2bin.sv */
// ----------------------------------------------------------------------------
// sai_therm2bin
// Turns a thermometer code (ones packed from bit 0) into its count.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_therm2bin import sai_pkg::*; (
    input  wire logic [SIZE-1:0] i_therm,
    output t_count               o_count
);

    logic [SIZE:0] w_step;

    always_comb begin
        w_step[0]    = ~i_therm[0];
        w_step[SIZE] = i_therm[SIZE-1];
        for (int k = 1; k < SIZE; k++) begin
            w_step[k] = i_therm[k-1] & ~i_therm[k];
        end
    end

    // one-hot step position to binary
    always_comb begin
        o_count = '0;
        for (int k = 0; k <= SIZE; k++) begin
            if (w_step[k]) begin
                o_count = o_count | CNT_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sorted_array_insert_counter.sv */
// ----------------------------------------------------------------------------
// sorted_array_insert_counter
// Ascending array held in a chain of cells; inserts shift larger entries up
// one slot and report comparison and move counts.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | handshake
//  i_req    | in  | cmd, value                                     | valid/ready
//  o_rsp    | out | comparisons, movements, stored, lost_last      | valid/ready
//
//  one request per cycle unless the response stalls; the response is registered
//  the cells compare and shift in the acceptance cycle, the counts are
//  encoded from the captured occupancy in the next stage
//  reset empties every cell and both stages
//  a stalled response holds the encode stage, then the request side
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_insert_counter import sai_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sai_in_if.sink    i_req,
    sai_out_if.source o_rsp
);

    t_entry          w_entry [SIZE];
    logic [SIZE-1:0] w_le;
    logic [SIZE-1:0] w_occ;
    t_cell_ctrl      w_ctrl;
    logic            w_accept;
    logic            w_b_free;
    logic            w_a_adv;
    t_entry          w_value;

    logic            r_a_valid;
    logic            r_a_ins;
    logic [SIZE-1:0] r_a_le;
    logic [SIZE-1:0] r_a_occ;

    logic            r_o_valid;
    t_cnt_field      r_comps;
    t_cnt_field      r_moves;
    logic            r_stored;
    logic            r_lost;

    t_count          w_pos;
    t_count          w_fill;
    logic            w_full;
    t_count          w_top;
    t_count          n_comps;
    t_count          n_moves;
    logic            n_stored;
    logic            n_lost;

    assign w_b_free    = !r_o_valid || o_rsp.ready;
    assign w_a_adv     = r_a_valid && w_b_free;
    assign i_req.ready = !r_a_valid || w_b_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_value     = VALUE_BITS'(i_req.value);

    assign w_ctrl.clear = w_accept && (i_req.cmd == CMD_CLEAR);
    assign w_ctrl.ins   = w_accept && (i_req.cmd == CMD_INSERT) && (w_value != '0);
    assign w_ctrl.value = w_value;

    for (genvar g = 0; g < SIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            sai_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_entry ('0),
                .i_prev_le    (1'b1),
                .o_entry      (w_entry[g]),
                .o_le         (w_le[g])
            );
        end else begin : g_body
            sai_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_entry (w_entry[g-1]),
                .i_prev_le    (w_le[g-1]),
                .o_entry      (w_entry[g]),
                .o_le         (w_le[g])
            );
        end
        assign w_occ[g] = (w_entry[g] != '0);
    end

    // capture stage: occupancy before the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_ins <= w_ctrl.ins;
            r_a_le  <= w_le;
            r_a_occ <= w_occ;
        end
    end

    sai_therm2bin u_pos (
        .i_therm (r_a_le),
        .o_count (w_pos)
    );

    sai_therm2bin u_fill (
        .i_therm (r_a_occ),
        .o_count (w_fill)
    );

    always_comb begin
        w_full   = r_a_occ[SIZE-1];
        w_top    = w_full ? CNT_W'(SIZE - 1) : w_fill;
        n_stored = r_a_ins && (w_pos != CNT_W'(SIZE));
        n_lost   = n_stored && w_full;
        n_moves  = (n_stored && (w_pos < w_fill)) ? (w_top - w_pos) : '0;
        if (!r_a_ins) begin
            n_comps = '0;
        end else if (w_pos == CNT_W'(SIZE)) begin
            n_comps = CNT_W'(SIZE);
        end else begin
            n_comps = w_pos + CNT_W'(1);
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_a_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_comps  <= CNT_FIELD_W'(n_comps);
            r_moves  <= CNT_FIELD_W'(n_moves);
            r_stored <= n_stored;
            r_lost   <= n_lost;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.comparisons = r_comps;
    assign o_rsp.movements   = r_moves;
    assign o_rsp.stored      = r_stored;
    assign o_rsp.lost_last   = r_lost;

endmodule

`default_nettype wire

/* hw/rtl/sai_checker.sv */
// ----------------------------------------------------------------------------
// sai_checker
// Port-level checks on the sorted array insert counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_checker import sai_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    sai_in_if.sink    i_req,
    sai_out_if.source o_rsp
);

    // a held response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid
            && $stable(o_rsp.comparisons) && $stable(o_rsp.movements)
            && $stable(o_rsp.stored) && $stable(o_rsp.lost_last))
        else $error("response changed while stalled");

    // nothing moves or falls off unless the value went in
    a_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.stored |-> o_rsp.movements == '0 && !o_rsp.lost_last)
        else $error("moves or loss without a store");

    // a stored value was compared at least once
    a_store_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.stored |-> o_rsp.comparisons != '0)
        else $error("store with zero comparisons");

    // a fresh response comes from an accepted request that passed the capture stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(i_req.valid && i_req.ready, 2))
        else $error("response without a request");

endmodule

bind sorted_array_insert_counter sai_checker u_sai_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);

`default_nettype wire
